FILE: rtl/core/qmn_pkg.sv
// Shared types, constants and helpers of the quaternion multiply/normalize block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package qmn_pkg;

  localparam int QMN_COMP_W      = 16;  // component width, Q2.14
  localparam int QMN_FRAC        = 14;
  localparam int QMN_TOL_W       = 29;
  localparam int QMN_PROD_W      = 33;  // one signed partial product
  localparam int QMN_ACC_W       = 35;  // sum of four products plus rounding
  localparam int QMN_C_W         = 20;  // rounded product component
  localparam int QMN_MAG_W       = 19;
  localparam int QMN_SQ_W        = 38;
  localparam int QMN_SUM_W       = 40;
  localparam int QMN_M_W         = 30;  // normalized magnitude
  localparam int QMN_NORM_TOP    = 29;
  localparam int QMN_X_W         = 62;  // sum of normalized squares
  localparam int QMN_ROOT_W      = 31;
  localparam int QMN_REM_W       = 33;
  localparam int QMN_Q_W         = 16;
  localparam int QMN_D_W         = 45;
  localparam int QMN_DREM_W      = 32;
  localparam int QMN_QUEUE_DEPTH = 4;

  localparam logic [QMN_TOL_W-1:0] QMN_TOL_RESET = 29'd26844;
  localparam logic [QMN_SUM_W-1:0] QMN_ONE       = 40'd1 << (2 * QMN_FRAC);

  // Hamilton product terms: component c, term t uses R[t] * S[QMN_RIDX[c][t]]
  localparam logic [1:0] QMN_RIDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic QMN_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_ZERO,
    CLS_RESCALE
  } qmn_cls_t;

  typedef logic [3:0][QMN_COMP_W-1:0] qmn_quat_t;

  typedef struct packed {
    logic [3:0][QMN_C_W-1:0] comp;
    qmn_cls_t                cls;
  } qmn_entry_t;

  // clamp a rounded component to the signed component range
  function automatic logic [QMN_COMP_W-1:0] qmn_sat(input logic [QMN_C_W-1:0] v);
    logic signed [QMN_C_W-1:0] sv;
    sv = $signed(v);
    if (sv > $signed(20'sd32767)) begin
      qmn_sat = 16'h7fff;
    end else if (sv < $signed(-20'sd32768)) begin
      qmn_sat = 16'h8000;
    end else begin
      qmn_sat = v[QMN_COMP_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/quaternion_multiply_normalise_top.sv
// Top level of the quaternion multiply and renormalize block.
// Instantiates qmn_front, qmn_queue and qmn_back; uses qmn_pkg.
`default_nettype none
// One transaction in, one out, at one item per clock while out_stall is low.
// The front end forms the Hamilton product R*S (Q2.14 in, rounded half up),
// its squared norm and a class: pass-through when the squared norm lies
// strictly within cfg tolerance of one, zero when it is zero, rescale
// otherwise. A four-entry queue decouples it from the back end, which shifts
// the magnitudes to a common scale, takes a 31-stage pipelined square root
// and runs four 16-stage pipelined dividers; results saturate to Q2.14.
// The data path holds 56 register stages: 3 front stages, the queue, 3
// normalize stages, 31 root stages, divider setup, 16 divide stages and
// the output register. cfg_ready is always high; write the tolerance only
// while the block is idle.
module quaternion_multiply_normalise_top #(
  parameter int QUEUE_DEPTH = qmn_pkg::QMN_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_scalar,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_i,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_j,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_k,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_scalar,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_i,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_j,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_k,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [qmn_pkg::QMN_COMP_W-1:0] out_p_scalar,
  output logic [qmn_pkg::QMN_COMP_W-1:0] out_p_i,
  output logic [qmn_pkg::QMN_COMP_W-1:0] out_p_j,
  output logic [qmn_pkg::QMN_COMP_W-1:0] out_p_k,
  output logic                          out_was_rescaled,
  output logic                          out_zero_norm,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qmn_pkg::QMN_TOL_W-1:0]  cfg_data
);
  import qmn_pkg::*;

  logic [QMN_TOL_W-1:0] tol_r;
  qmn_quat_t            r, s, p;
  qmn_entry_t           push_data, head;
  logic                 push, full, pop, not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= QMN_TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  assign r = {in_r_k, in_r_j, in_r_i, in_r_scalar};
  assign s = {in_s_k, in_s_j, in_s_i, in_s_scalar};

  qmn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .r        (r),
    .s        (s),
    .tol      (tol_r),
    .q_full   (full),
    .push     (push),
    .entry    (push_data)
  );

  qmn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  qmn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (not_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .p            (p),
    .was_rescaled (out_was_rescaled),
    .zero_norm    (out_zero_norm)
  );

  assign out_p_scalar = p[0];
  assign out_p_i      = p[1];
  assign out_p_j      = p[2];
  assign out_p_k      = p[3];

endmodule
`default_nettype wire

FILE: rtl/core/qmn_front.sv
// Front end: Hamilton product, rounding, squared norm and classification.
// Depends on qmn_pkg; pushes one classified entry per transaction into qmn_queue.
`default_nettype none
module qmn_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  qmn_pkg::qmn_quat_t          r,
  input  qmn_pkg::qmn_quat_t          s,
  input  logic [qmn_pkg::QMN_TOL_W-1:0] tol,
  input  logic                        q_full,
  output logic                        push,
  output qmn_pkg::qmn_entry_t         entry
);
  import qmn_pkg::*;

  logic                          en;
  logic                          s1_vld_r, s2_vld_r, s3_vld_r;
  logic [QMN_PROD_W-1:0]         prod_r [4][4];
  logic [QMN_PROD_W-1:0]         prod_nxt [4][4];
  logic [3:0][QMN_C_W-1:0]       c2_r, c2_nxt, c3_r;
  logic [QMN_SQ_W-1:0]           sq_r [4];
  logic [QMN_SQ_W-1:0]           sq_nxt [4];
  logic [QMN_SUM_W-1:0]          sum;
  logic [QMN_SUM_W-1:0]          distance;

  // hold the whole front while the last stage cannot push
  assign en       = !(s3_vld_r && q_full);
  assign in_stall = !en;
  assign push     = s3_vld_r && !q_full;

  always_comb begin
    logic signed [QMN_PROD_W-1:0] p;
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        p = $signed(r[t]) * $signed(s[QMN_RIDX[c][t]]);
        if (QMN_NEG[c][t]) begin
          p = -p;
        end
        prod_nxt[c][t] = p;
      end
    end
  end

  // round half up, then floor-shift by the fraction width
  always_comb begin
    logic signed [QMN_ACC_W-1:0] acc;
    for (int c = 0; c < 4; c++) begin
      acc = QMN_ACC_W'($signed(prod_r[c][0])) + QMN_ACC_W'($signed(prod_r[c][1]))
          + QMN_ACC_W'($signed(prod_r[c][2])) + QMN_ACC_W'($signed(prod_r[c][3]))
          + QMN_ACC_W'(1 << (QMN_FRAC - 1));
      c2_nxt[c] = acc[QMN_FRAC+QMN_C_W-1:QMN_FRAC];
    end
  end

  always_comb begin
    logic [QMN_C_W-1:0]   neg;
    logic [QMN_MAG_W-1:0] mag;
    for (int c = 0; c < 4; c++) begin
      neg = -c2_r[c];
      mag = c2_r[c][QMN_C_W-1] ? neg[QMN_MAG_W-1:0] : c2_r[c][QMN_MAG_W-1:0];
      sq_nxt[c] = QMN_SQ_W'(mag) * QMN_SQ_W'(mag);
    end
  end

  always_comb begin
    sum = QMN_SUM_W'(sq_r[0]) + QMN_SUM_W'(sq_r[1]) + QMN_SUM_W'(sq_r[2])
        + QMN_SUM_W'(sq_r[3]);
    distance = (sum > QMN_ONE) ? (sum - QMN_ONE) : (QMN_ONE - sum);
    entry.comp = c3_r;
    if (sum == '0) begin
      entry.cls = CLS_ZERO;
    end else if (distance < QMN_SUM_W'(tol)) begin
      entry.cls = CLS_PASS;
    end else begin
      entry.cls = CLS_RESCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      c2_r   <= c2_nxt;
      c3_r   <= c2_r;
      sq_r   <= sq_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/qmn_queue.sv
// Short FIFO between the classifying front end and the normalizing back end.
// Depends on qmn_pkg for the entry type.
`default_nettype none
module qmn_queue #(
  parameter int DEPTH = qmn_pkg::QMN_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qmn_pkg::qmn_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output qmn_pkg::qmn_entry_t head
);
  import qmn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qmn_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/qmn_back.sv
// Back end: normalizing shift, squared sum, pipelined square root and four
// pipelined dividers, then sign, saturation and the output register. Uses qmn_pkg.
`default_nettype none
module qmn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  qmn_pkg::qmn_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output qmn_pkg::qmn_quat_t  p,
  output logic                was_rescaled,
  output logic                zero_norm
);
  import qmn_pkg::*;

  typedef struct packed {
    logic                       vld;
    qmn_cls_t                   cls;
    logic [3:0]                 neg;
    logic [3:0][QMN_COMP_W-1:0] pass;
    logic [3:0][QMN_M_W-1:0]    m;
  } qmn_nrm_t;

  typedef struct packed {
    logic                       vld;
    qmn_cls_t                   cls;
    logic [3:0]                 neg;
    logic [3:0][QMN_COMP_W-1:0] pass;
    logic [3:0][QMN_M_W-1:0]    m;
    logic [QMN_X_W-1:0]         x;
    logic [QMN_REM_W-1:0]       rem;
    logic [QMN_ROOT_W-1:0]      root;
  } qmn_sqrt_t;

  typedef struct packed {
    logic                       vld;
    qmn_cls_t                   cls;
    logic [3:0]                 neg;
    logic [3:0][QMN_COMP_W-1:0] pass;
    logic [QMN_ROOT_W-1:0]      n;
    logic [3:0][QMN_Q_W-1:0]    d_lo;
    logic [3:0][QMN_DREM_W-1:0] drem;
    logic [3:0][QMN_Q_W-1:0]    q;
  } qmn_div_t;

  localparam int SQ_STEPS  = QMN_ROOT_W;
  localparam int DIV_STEPS = QMN_Q_W;

  logic                    en;
  qmn_nrm_t                b0_r, b0_nxt, b1_r;
  logic [QMN_X_W-1:0]      b1_sq_r [4];
  logic [QMN_X_W-1:0]      b1_sq_nxt [4];
  qmn_sqrt_t               sq_r [SQ_STEPS+1];
  qmn_sqrt_t               sq_nxt [SQ_STEPS+1];
  qmn_div_t                dv_r [DIV_STEPS+1];
  qmn_div_t                dv_nxt [DIV_STEPS+1];
  logic                    out_valid_r, out_resc_r, out_zero_r;
  qmn_quat_t               out_p_r, out_p_nxt;

  // advance the whole back pipeline unless the output is held
  assign en  = !(out_valid_r && out_stall);
  assign pop = en && q_valid;

  // find the leading one of the largest magnitude and line it up at bit 29
  always_comb begin
    logic [QMN_C_W-1:0]   neg;
    logic [QMN_MAG_W-1:0] mag [4];
    logic [QMN_MAG_W-1:0] mag_or;
    logic [4:0]           top;
    logic [4:0]           shift;
    mag_or = '0;
    for (int c = 0; c < 4; c++) begin
      neg    = -head.comp[c];
      mag[c] = head.comp[c][QMN_C_W-1] ? neg[QMN_MAG_W-1:0] : head.comp[c][QMN_MAG_W-1:0];
      mag_or = mag_or | mag[c];
    end
    top = '0;
    for (int b = 0; b < QMN_MAG_W; b++) begin
      if (mag_or[b]) begin
        top = 5'(b);
      end
    end
    shift = 5'(QMN_NORM_TOP) - top;
    b0_nxt.vld = pop;
    b0_nxt.cls = head.cls;
    for (int c = 0; c < 4; c++) begin
      b0_nxt.neg[c]  = head.comp[c][QMN_C_W-1];
      b0_nxt.pass[c] = qmn_sat(head.comp[c]);
      b0_nxt.m[c]    = QMN_M_W'(mag[c]) << shift;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      b1_sq_nxt[c] = QMN_X_W'(b0_r.m[c]) * QMN_X_W'(b0_r.m[c]);
    end
  end

  always_comb begin
    sq_nxt[0].vld  = b1_r.vld;
    sq_nxt[0].cls  = b1_r.cls;
    sq_nxt[0].neg  = b1_r.neg;
    sq_nxt[0].pass = b1_r.pass;
    sq_nxt[0].m    = b1_r.m;
    sq_nxt[0].x    = b1_sq_r[0] + b1_sq_r[1] + b1_sq_r[2] + b1_sq_r[3];
    sq_nxt[0].rem  = '0;
    sq_nxt[0].root = '0;
  end

  // one root bit per stage, two radicand bits taken in each
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int PAIR = SQ_STEPS - 1 - k;
    always_comb begin
      logic [QMN_REM_W+1:0] rem_sh;
      logic [QMN_REM_W+1:0] trial;
      sq_nxt[k+1] = sq_r[k];
      rem_sh = {sq_r[k].rem, sq_r[k].x[2*PAIR+1 -: 2]};
      trial  = (QMN_REM_W+2)'({sq_r[k].root, 2'b01});
      if (rem_sh >= trial) begin
        sq_nxt[k+1].rem  = QMN_REM_W'(rem_sh - trial);
        sq_nxt[k+1].root = {sq_r[k].root[QMN_ROOT_W-2:0], 1'b1};
      end else begin
        sq_nxt[k+1].rem  = QMN_REM_W'(rem_sh);
        sq_nxt[k+1].root = {sq_r[k].root[QMN_ROOT_W-2:0], 1'b0};
      end
    end
  end

  // dividend is m * 2^14 plus half the norm; its top bits already sit below N
  always_comb begin
    logic [QMN_D_W-1:0] d;
    dv_nxt[0].vld  = sq_r[SQ_STEPS].vld;
    dv_nxt[0].cls  = sq_r[SQ_STEPS].cls;
    dv_nxt[0].neg  = sq_r[SQ_STEPS].neg;
    dv_nxt[0].pass = sq_r[SQ_STEPS].pass;
    dv_nxt[0].n    = sq_r[SQ_STEPS].root;
    dv_nxt[0].q    = '0;
    for (int c = 0; c < 4; c++) begin
      d = {sq_r[SQ_STEPS].m[c], QMN_FRAC'(0)}
        + QMN_D_W'(sq_r[SQ_STEPS].root >> 1);
      dv_nxt[0].d_lo[c] = d[QMN_Q_W-1:0];
      dv_nxt[0].drem[c] = QMN_DREM_W'(d[QMN_D_W-1:QMN_Q_W]);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int BIT = DIV_STEPS - 1 - j;
    always_comb begin
      logic [QMN_DREM_W-1:0] rem_sh;
      dv_nxt[j+1] = dv_r[j];
      for (int c = 0; c < 4; c++) begin
        rem_sh = {dv_r[j].drem[c][QMN_DREM_W-2:0], dv_r[j].d_lo[c][BIT]};
        if (rem_sh >= QMN_DREM_W'(dv_r[j].n)) begin
          dv_nxt[j+1].drem[c] = rem_sh - QMN_DREM_W'(dv_r[j].n);
          dv_nxt[j+1].q[c]    = {dv_r[j].q[c][QMN_Q_W-2:0], 1'b1};
        end else begin
          dv_nxt[j+1].drem[c] = rem_sh;
          dv_nxt[j+1].q[c]    = {dv_r[j].q[c][QMN_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [QMN_C_W-1:0] v;
    for (int c = 0; c < 4; c++) begin
      v = {4'b0, dv_r[DIV_STEPS].q[c]};
      if (dv_r[DIV_STEPS].neg[c]) begin
        v = -v;
      end
      case (dv_r[DIV_STEPS].cls)
        CLS_PASS:    out_p_nxt[c] = dv_r[DIV_STEPS].pass[c];
        CLS_ZERO:    out_p_nxt[c] = '0;
        CLS_RESCALE: out_p_nxt[c] = qmn_sat(v);
        default:     out_p_nxt[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r.vld    <= 1'b0;
      b1_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_r[k].vld <= 1'b0;
      end
      for (int j = 0; j <= DIV_STEPS; j++) begin
        dv_r[j].vld <= 1'b0;
      end
    end else if (en) begin
      b0_r        <= b0_nxt;
      b1_r        <= b0_r;
      sq_r        <= sq_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= dv_r[DIV_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_sq_r    <= b1_sq_nxt;
      out_p_r    <= out_p_nxt;
      out_resc_r <= (dv_r[DIV_STEPS].cls == CLS_RESCALE);
      out_zero_r <= (dv_r[DIV_STEPS].cls == CLS_ZERO);
    end
  end

  assign out_valid    = out_valid_r;
  assign p            = out_p_r;
  assign was_rescaled = out_resc_r;
  assign zero_norm    = out_zero_r;

endmodule
`default_nettype wire

FILE: verif/qmn_checker.sv
// Checker for the quaternion multiply and renormalize block: watches the input,
// result and tolerance write channels, predicts each product and compares. Uses qmn_pkg.
module qmn_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_scalar,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_i,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_j,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_r_k,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_scalar,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_i,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_j,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] in_s_k,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] out_p_scalar,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] out_p_i,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] out_p_j,
  input  logic [qmn_pkg::QMN_COMP_W-1:0] out_p_k,
  input  logic                           out_was_rescaled,
  input  logic                           out_zero_norm,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [qmn_pkg::QMN_TOL_W-1:0]  cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  import qmn_pkg::*;

  typedef struct packed {
    logic [3:0][15:0] p;
    logic             rescaled;
    logic             zero;
  } product_t;

  product_t             expected_products[$];
  logic [QMN_TOL_W-1:0] tolerance;

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint isqrt(longint unsigned x);
    longint unsigned root, bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= root + bit_w) begin
        x -= root + bit_w;
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  function automatic product_t predict_product(logic [3:0][15:0] rq, logic [3:0][15:0] sq);
    product_t             res;
    longint               comp[4];
    longint unsigned      mag[4];
    longint unsigned      biggest, sum, distance, norm, q;
    longint               acc, term;
    logic                 in_range;
    int                   top;
    res = '0;
    biggest = 0;
    in_range = 1;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int t = 0; t < 4; t++) begin
        term = longint'($signed(rq[t])) * longint'($signed(sq[QMN_RIDX[c][t]]));
        acc += QMN_NEG[c][t] ? -term : term;
      end
      // round half up: add half then arithmetic shift floors
      comp[c] = (acc + (64'sd1 << (QMN_FRAC - 1))) >>> QMN_FRAC;
      mag[c] = comp[c] < 0 ? -comp[c] : comp[c];
      if (mag[c] >= (64'd1 << 31)) in_range = 0;
      if (mag[c] > biggest) biggest = mag[c];
    end
    if (in_range) begin
      sum = 0;
      for (int c = 0; c < 4; c++) sum += mag[c] * mag[c];
      if (sum == 0) begin
        res.zero = 1;
        return res;
      end
      distance = sum > (64'd1 << 28) ? sum - (64'd1 << 28) : (64'd1 << 28) - sum;
      if (distance < tolerance) begin
        for (int c = 0; c < 4; c++) res.p[c] = clamp16(comp[c]);
        return res;
      end
    end
    top = 63;
    while (top > 0 && biggest[top] == 0) top--;
    sum = 0;
    for (int c = 0; c < 4; c++) begin
      if (top < QMN_NORM_TOP) mag[c] <<= (QMN_NORM_TOP - top);
      else mag[c] >>= (top - QMN_NORM_TOP);
      sum += mag[c] * mag[c];
    end
    norm = isqrt(sum);
    for (int c = 0; c < 4; c++) begin
      q = ((mag[c] << QMN_FRAC) + (norm >> 1)) / norm;
      res.p[c] = clamp16(comp[c] < 0 ? -longint'(q) : longint'(q));
    end
    res.rescaled = 1;
    return res;
  endfunction

  always @(posedge clk) begin
    product_t want, got;
    if (!rst_n) begin
      tolerance <= QMN_TOL_RESET;
      fail_count <= 0;
      expected_products.delete();
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (in_valid && !in_stall)
        expected_products.push_back(predict_product(
          {in_r_k, in_r_j, in_r_i, in_r_scalar}, {in_s_k, in_s_j, in_s_i, in_s_scalar}));
      if (out_valid && !out_stall) begin
        got.p = {out_p_k, out_p_j, out_p_i, out_p_scalar};
        got.rescaled = out_was_rescaled;
        got.zero = out_zero_norm;
        if (expected_products.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected product %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_products.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("ERROR: product mismatch exp p=%h resc=%b zero=%b got p=%h resc=%b zero=%b",
                       want.p, want.rescaled, want.zero, got.p, got.rescaled, got.zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_products.size();
endmodule

FILE: verif/quaternion_multiply_normalise_top_tb.sv
// Testbench top: drives quaternion pairs and tolerance writes into the block and
// gives the verdict. Depends on qmn_pkg, the RTL top and qmn_checker.
module quaternion_multiply_normalise_top_tb;
  import qmn_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [3:0][15:0] r_q = '0, s_q = '0;
  logic [15:0] p_scalar, p_i, p_j, p_k;
  logic was_rescaled, zero_norm;
  logic cfg_valid = 0, cfg_ready;
  logic [QMN_TOL_W-1:0] cfg_data = '0;
  int fail_count, pending_count;
  logic calm = 0;
  logic hold_off = 0;

  always #5 clk = ~clk;

  quaternion_multiply_normalise_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_r_scalar(r_q[0]), .in_r_i(r_q[1]), .in_r_j(r_q[2]), .in_r_k(r_q[3]),
    .in_s_scalar(s_q[0]), .in_s_i(s_q[1]), .in_s_j(s_q[2]), .in_s_k(s_q[3]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_p_scalar(p_scalar), .out_p_i(p_i), .out_p_j(p_j), .out_p_k(p_k),
    .out_was_rescaled(was_rescaled), .out_zero_norm(zero_norm),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  qmn_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_r_scalar(r_q[0]), .in_r_i(r_q[1]), .in_r_j(r_q[2]), .in_r_k(r_q[3]),
    .in_s_scalar(s_q[0]), .in_s_i(s_q[1]), .in_s_j(s_q[2]), .in_s_k(s_q[3]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_p_scalar(p_scalar), .out_p_i(p_i), .out_p_j(p_j), .out_p_k(p_k),
    .out_was_rescaled(was_rescaled), .out_zero_norm(zero_norm),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      5, 6: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  // send one transaction; hold until accepted, leave valid high for the next
  task automatic send_product(logic [3:0][15:0] rv, logic [3:0][15:0] sv);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    r_q <= rv;
    s_q <= sv;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic unit_pair(output logic [3:0][15:0] rv, output logic [3:0][15:0] sv);
    // unit quaternions with small random error, near the tolerance edge
    rv = '0;
    sv = '0;
    rv[$urandom_range(0, 3)] = 16'h4000 + 16'($urandom_range(0, 6)) - 16'd3;
    sv[$urandom_range(0, 3)] = ($urandom_range(0, 1) ? 16'h4000 : 16'hc000)
                               + 16'($urandom_range(0, 2)) - 16'd1;
  endtask

  task automatic drain_and_write(logic [QMN_TOL_W-1:0] tol);
    while (pending_count != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    cfg_data <= tol;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    logic [3:0][15:0] rv, sv;
    logic [QMN_TOL_W-1:0] tols[5];
    tols = '{29'd0, 29'h1fffffff, 29'd26844, 29'd268435456, 29'd1000};
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: zero, identity, extremes, signs of each term
    send_product('0, '0);
    send_product({16'h0, 16'h0, 16'h0, 16'h4000}, {16'h0, 16'h0, 16'h0, 16'h4000});
    send_product({4{16'h8000}}, {4{16'h8000}});
    send_product({4{16'h7fff}}, {4{16'h8000}});
    send_product({4{16'h7fff}}, {4{16'h7fff}});
    send_product({16'h0, 16'h0, 16'h4000, 16'h0}, {16'h0, 16'h4000, 16'h0, 16'h0});
    send_product({16'h4000, 16'h0, 16'h0, 16'h0}, {16'h0, 16'h4000, 16'h0, 16'h0});
    send_product({16'h0, 16'h0, 16'h0, 16'h2000}, {16'h0, 16'h0, 16'h0, 16'h2000});
    send_product({16'h0, 16'h0, 16'h0, 16'h0001}, {16'h0, 16'h0, 16'h0, 16'h0001});
    send_product({16'h0, 16'h0, 16'h0, 16'h0001}, {16'h0, 16'h0, 16'h0, 16'h2000});
    send_product({16'h0, 16'h0, 16'h0, 16'hffff}, {16'h0, 16'h0, 16'h0, 16'h2000});
    send_product({16'h1234, 16'h5678, 16'h9abc, 16'hdef0},
                 {16'h0fed, 16'hcba9, 16'h8765, 16'h4321});

    // fill the block against a long receiver hold-off
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      begin
        repeat (80) begin
          unit_pair(rv, sv);
          send_product(rv, sv);
        end
        in_valid <= 0;
      end
    join

    for (int phase = 0; phase < 5; phase++) begin
      drain_and_write(tols[phase]);
      if (phase == 4) calm = 1;
      repeat (210) begin
        if ($urandom_range(0, 2) != 0) begin
          unit_pair(rv, sv);
        end else begin
          for (int c = 0; c < 4; c++) begin
            rv[c] = pick_comp();
            sv[c] = pick_comp();
          end
        end
        send_product(rv, sv);
      end
      in_valid <= 0;
    end

    while (pending_count != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
